>>> rtl/plid_pkg.sv
// shared types, request and status codes for the positional list core
package plid_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int REQ_W     = 3;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    typedef logic [REQ_W-1:0]           req_t;
    typedef logic signed [DATA_W-1:0]   data_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;

    localparam req_t REQ_INS_FRONT = 3'd0;
    localparam req_t REQ_INS_POS   = 3'd1;
    localparam req_t REQ_INS_END   = 3'd2;
    localparam req_t REQ_DEL_FRONT = 3'd3;
    localparam req_t REQ_DEL_POS   = 3'd4;
    localparam req_t REQ_DEL_END   = 3'd5;
    localparam req_t REQ_READ      = 3'd6;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
    } cell_sel_t;

endpackage

>>> rtl/plid_if.sv
// valid/ready channel interfaces for requests and responses
interface plid_req_if;
    logic             valid;
    logic             ready;
    plid_pkg::req_t   req_type;
    plid_pkg::data_t  item_value;
    plid_pkg::pos_t   position;

    modport source (output valid, output req_type, output item_value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input item_value, input position,
                    output ready);
endinterface

interface plid_rsp_if;
    logic               valid;
    logic               ready;
    plid_pkg::status_t  status;
    plid_pkg::count_t   entry_count;
    plid_pkg::data_t    read_value;

    modport source (output valid, output status, output entry_count, output read_value,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input read_value,
                    output ready);
endinterface

>>> rtl/plid_cell.sv
// one list cell: holds an entry and takes a new value or a neighbor's on a shift
module plid_cell
(
    input  logic                clk,
    input  plid_pkg::cell_sel_t sel,
    input  plid_pkg::data_t     new_value,
    input  plid_pkg::data_t     left_value,
    input  plid_pkg::data_t     right_value,
    output plid_pkg::data_t     value
);

    plid_pkg::data_t value_reg;
    plid_pkg::data_t value_next;

    always_comb
    begin
        priority if (sel.take_new)
        begin
            value_next = new_value;
        end
        else if (sel.take_left)
        begin
            value_next = left_value;
        end
        else if (sel.take_right)
        begin
            value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/positional_list_insert_delete_core.sv
// positional list core: ordered list of signed values held in a row of shifting cells
//
// channels: req (sink) carries req_type, item_value and position; rsp (source)
// carries status, entry_count and read_value, one response beat per request beat.
// requests: insert at front / at position / at end, delete at front / at position /
// at end, read at position. an insert position past the end appends; a delete or
// read at or past the end is out of range (empty if the list is) and changes nothing.
// latency: the response beat is valid in the cycle after the request beat.
// throughput: one request per cycle while the response register is free or being
// taken; every cell at or past the target position shifts in the same cycle, at
// any depth. read is one DEPTH-way mux off the cell row.
// stall: the response sits in an output register; req.ready is high while that
// register is empty or being taken, so a stalled receiver holds one beat and
// stops new requests until it drains.
// reset: the count and the response valid clear at once; cell contents are
// undefined until written and are only ever read below the count.
module positional_list_insert_delete_core
#(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    plid_req_if.sink     req,
    plid_rsp_if.source   rsp
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W;

    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    plid_pkg::status_t    status_reg;
    plid_pkg::count_t     count_reg;
    plid_pkg::data_t      read_reg;

    plid_pkg::data_t      cell_q [DEPTH];
    plid_pkg::cell_sel_t  sel    [DEPTH];

    logic [CMPW-1:0]      cnt_x;
    logic [CMPW-1:0]      pos_x;
    logic [CMPW-1:0]      at;
    logic                 is_ins;
    logic                 is_del;
    logic                 is_rd;
    logic                 full;
    logic                 empty;
    logic                 out_range;
    logic                 accept;
    logic                 do_ins;
    logic                 do_del;
    plid_pkg::status_t    st;
    plid_pkg::data_t      rd_val;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign cnt_x = CMPW'(cnt_reg);
    assign pos_x = CMPW'(req.position);
    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);

    // position decode
    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        is_rd  = 1'b0;
        at     = '0;
        unique case (req.req_type)
            plid_pkg::REQ_INS_FRONT:
            begin
                is_ins = 1'b1;
                at     = '0;
            end
            plid_pkg::REQ_INS_POS:
            begin
                is_ins = 1'b1;
                at     = (pos_x > cnt_x) ? cnt_x : pos_x;
            end
            plid_pkg::REQ_INS_END:
            begin
                is_ins = 1'b1;
                at     = cnt_x;
            end
            plid_pkg::REQ_DEL_FRONT:
            begin
                is_del = 1'b1;
                at     = '0;
            end
            plid_pkg::REQ_DEL_POS:
            begin
                is_del = 1'b1;
                at     = pos_x;
            end
            plid_pkg::REQ_DEL_END:
            begin
                is_del = 1'b1;
                at     = cnt_x - CMPW'(1);
            end
            plid_pkg::REQ_READ:
            begin
                is_rd = 1'b1;
                at    = pos_x;
            end
            default:
            begin
                at = '0;
            end
        endcase
    end

    assign out_range = (at >= cnt_x);

    always_comb
    begin
        priority if (is_ins && full)
        begin
            st = plid_pkg::ST_FULL;
        end
        else if ((is_del || is_rd) && empty)
        begin
            st = plid_pkg::ST_EMPTY;
        end
        else if ((is_del || is_rd) && out_range)
        begin
            st = plid_pkg::ST_RANGE;
        end
        else
        begin
            st = plid_pkg::ST_OK;
        end
    end

    assign do_ins = accept && is_ins && !full;
    assign do_del = accept && is_del && !empty && !out_range;

    assign rd_val = (is_rd && !empty && !out_range) ? cell_q[at[IW-1:0]] : '0;

    always_comb
    begin
        priority if (do_ins)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_del)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CMPW-1:0] IDX = CMPW'(i);
        plid_pkg::data_t left_q;
        plid_pkg::data_t right_q;

        if (i == 0)
        begin : g_first
            assign left_q = cell_q[i];
        end
        else
        begin : g_inner_left
            assign left_q = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_q = cell_q[i];
        end
        else
        begin : g_inner_right
            assign right_q = cell_q[i+1];
        end

        assign sel[i].take_new   = do_ins && (at == IDX);
        assign sel[i].take_left  = do_ins && (at < IDX);
        assign sel[i].take_right = do_del && (at <= IDX);

        plid_cell u_cell
        (
            .clk         (clk),
            .sel         (sel[i]),
            .new_value   (req.item_value),
            .left_value  (left_q),
            .right_value (right_q),
            .value       (cell_q[i])
        );
    end

    assign rsp_valid_next = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= st;
            count_reg  <= plid_pkg::count_t'(cnt_next);
            read_reg   <= rd_val;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.read_value  = read_reg;

endmodule

>>> rtl/plid_checker.sv
// port-level checks for the positional list core, bound to the top level
module plid_checker
#(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input plid_pkg::status_t  status,
    input plid_pkg::count_t   entry_count,
    input plid_pkg::data_t    read_value
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(entry_count) && $stable(read_value))
        else $error("response beat changed while stalled");

    // every request beat yields a response beat next cycle
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("request beat without response");

    // full status only with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == plid_pkg::ST_FULL
            |-> entry_count == plid_pkg::count_t'(DEPTH))
        else $error("full status with list not full");

    // empty status only with an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == plid_pkg::ST_EMPTY |-> entry_count == '0)
        else $error("empty status with entries held");

endmodule

bind positional_list_insert_delete_core plid_checker #(.DEPTH(DEPTH)) u_plid_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .entry_count (rsp.entry_count),
    .read_value  (rsp.read_value)
);
